/* sv/tree_ring_link_map_top_defines.svh */
// assertion macros for the tree and ring link map checker
// clocked on clk, disabled while arst_n is low
`ifndef TREE_RING_LINK_MAP_TOP_DEFINES_SVH
`define TREE_RING_LINK_MAP_TOP_DEFINES_SVH

// antecedent and consequent in the same cycle
`define TRLM_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent in the cycle after the antecedent
`define TRLM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* sv/trlm_pkg.sv */
// shared constants and types for the tree and ring link map
// no dependencies
`default_nettype none

package trlm_pkg;

	localparam int MAX_WORKERS = 64;
	localparam int WALK_DEPTH  = 7;
	localparam int RANK_W      = $clog2(MAX_WORKERS);
	localparam int COUNT_W     = $clog2(MAX_WORKERS + 1);
	localparam int SP_W        = $clog2(WALK_DEPTH + 1);

	typedef logic [RANK_W-1:0]  rank_t;
	typedef logic [COUNT_W-1:0] count_t;

	typedef struct packed {
		rank_t      node;
		logic       rev;
		logic [1:0] step;
	} frame_t;

	typedef struct packed {
		rank_t      new_rank;
		rank_t      old_rank;
		logic       has_parent;
		rank_t      parent_rank;
		logic [1:0] child_count;
		rank_t      first_child;
		rank_t      second_child;
		rank_t      ring_prev;
		rank_t      ring_next;
		logic       last_flag;
	} result_t;

endpackage

`default_nettype wire

/* sv/trlm_job_if.sv */
// request channel: one word carries a worker count
// depends on trlm_pkg
`default_nettype none

interface trlm_job_if import trlm_pkg::*;;
	logic         valid;
	logic         ready;
	logic [6:0]   worker_count;

	modport source (output valid, output worker_count, input ready);
	modport sink   (input valid, input worker_count, output ready);
endinterface

`default_nettype wire

/* sv/trlm_res_if.sv */
// result channel: one word per relabelled worker
// depends on trlm_pkg
`default_nettype none

interface trlm_res_if import trlm_pkg::*;;
	logic       valid;
	logic       ready;
	rank_t      new_rank;
	rank_t      old_rank;
	logic       has_parent;
	rank_t      parent_rank;
	logic [1:0] child_count;
	rank_t      first_child;
	rank_t      second_child;
	rank_t      ring_prev;
	rank_t      ring_next;
	logic       last_flag;

	modport source (
		output valid, output new_rank, output old_rank, output has_parent,
		output parent_rank, output child_count, output first_child,
		output second_child, output ring_prev, output ring_next, output last_flag,
		input ready
	);
	modport sink (
		input valid, input new_rank, input old_rank, input has_parent,
		input parent_rank, input child_count, input first_child,
		input second_child, input ring_prev, input ring_next, input last_flag,
		output ready
	);
endinterface

`default_nettype wire

/* sv/tree_ring_link_map_top.sv */
// tree and ring link map: heap tree walk, ring relabelling and per-worker links
// depends on trlm_pkg, trlm_job_if, trlm_res_if
//
// job channel takes one word holding a worker count n; ready is high only while
// the block is idle. a count of zero or above 64 is dropped with no result.
// result channel gives n words, new rank 0 to n-1 in order, last_flag on the
// final one. each word holds the old heap rank, relabelled parent and children
// and ring neighbours.
// timing: the depth-first walk makes one stack step a cycle and writes the
// ring order and ring position memories. each result then steps through
// S_RD_ORD, S_RD_PAR, S_RD_LEFT, S_RD_RIGHT and S_SEND, set by the single read
// port of the ring position memory (parent, left and right child read in turn).
// the result register lets the block prepare the next word while the current
// one waits; while the receiver stalls the sequencer holds before loading.
// reset returns the sequencer to idle and empties the result register; the
// memories keep their contents and need no clearing pass since each job
// writes every entry whose value it uses.
`default_nettype none

module tree_ring_link_map_top import trlm_pkg::*; (
	input  wire         clk,
	input  wire         arst_n,
	trlm_job_if.sink    job,
	trlm_res_if.source  result
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_WALK,
		S_RD_ORD,
		S_RD_PAR,
		S_RD_LEFT,
		S_RD_RIGHT,
		S_SEND
	} state_t;

	state_t            state_q;
	count_t            n_q;
	count_t            cnt_q;
	logic [SP_W-1:0]   sp_q;
	rank_t             p_q;
	rank_t             old_q;
	rank_t             par_q;
	rank_t             c1_q;
	result_t           res_q;
	logic              res_valid_q;

	rank_t             ring_order_mem [MAX_WORKERS];
	rank_t             ring_position_mem [MAX_WORKERS];
	rank_t             ord_rd_q;
	rank_t             pos_rd_q;
	frame_t            walk_stack_q [WALK_DEPTH];

	// walk step
	frame_t            top_f;
	logic [SP_W-1:0]   top_idx;
	logic [6:0]        w_left;
	logic [7:0]        w_right;
	logic              w_has_l;
	logic              w_has_r;
	logic [1:0]        w_nc;
	logic [1:0]        w_total;
	logic              w_pop;
	logic [1:0]        w_j;
	logic              w_emit;
	logic              w_push;
	frame_t            w_new_f;

	// emit step
	logic              job_ok;
	logic              res_free;
	logic              e_last;
	logic [6:0]        e_left;
	logic [7:0]        e_right;
	logic              e_has_l;
	logic              e_has_r;
	rank_t             par_addr;
	rank_t             pos_raddr;
	logic              pos_re;
	result_t           res_d;

	assign job.ready = (state_q == S_IDLE);
	assign job_ok    = (job.worker_count != 7'd0) &&
	                   ({1'b0, job.worker_count} <= 8'(MAX_WORKERS));

	assign top_idx = sp_q - 1'b1;
	assign top_f   = walk_stack_q[top_idx[SP_W-1:0]];
	assign w_left  = {top_f.node, 1'b1};
	assign w_right = {1'b0, top_f.node, 1'b0} + 8'd2;
	assign w_has_l = {1'b0, w_left} < {1'b0, n_q};
	assign w_has_r = w_right < {1'b0, n_q};
	assign w_nc    = {1'b0, w_has_l} + {1'b0, w_has_r};
	assign w_total = 2'd1 + w_nc;
	assign w_pop   = top_f.step >= w_total;
	assign w_j     = top_f.rev ? (w_total - 2'd1 - top_f.step) : top_f.step;
	assign w_emit  = (state_q == S_WALK) && !w_pop && (w_j == 2'd0) &&
	                 (cnt_q < count_t'(MAX_WORKERS));
	assign w_push  = (state_q == S_WALK) && !w_pop && (w_j != 2'd0) &&
	                 (sp_q < SP_W'(WALK_DEPTH));

	always_comb begin
		w_new_f = '0;
		if (w_j == 2'd1) begin
			w_new_f.node = w_left[RANK_W-1:0];
			w_new_f.rev  = (w_nc == 2'd1) ^ top_f.rev;
		end else begin
			w_new_f.node = w_right[RANK_W-1:0];
			w_new_f.rev  = ~top_f.rev;
		end
	end

	// walk stack
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && job.valid && job_ok) begin
			walk_stack_q[0] <= '0;
		end else if (state_q == S_WALK && !w_pop) begin
			walk_stack_q[top_idx] <= '{node: top_f.node, rev: top_f.rev,
			                           step: top_f.step + 2'd1};
			if (w_push) begin
				walk_stack_q[sp_q[SP_W-1:0]] <= w_new_f;
			end
		end
	end

	// ring order and ring position memories
	always_ff @(posedge clk) begin
		if (w_emit) begin
			ring_order_mem[cnt_q[RANK_W-1:0]] <= top_f.node;
			ring_position_mem[top_f.node]     <= cnt_q[RANK_W-1:0];
		end
		ord_rd_q <= ring_order_mem[p_q];
		if (pos_re) begin
			pos_rd_q <= ring_position_mem[pos_raddr];
		end
	end

	assign e_left   = {old_q, 1'b1};
	assign e_right  = {1'b0, old_q, 1'b0} + 8'd2;
	assign e_has_l  = {1'b0, e_left} < {1'b0, n_q};
	assign e_has_r  = e_right < {1'b0, n_q};
	assign par_addr = (ord_rd_q - 1'b1) >> 1;
	assign e_last   = ({1'b0, p_q} == n_q - 1'b1);
	assign res_free = !res_valid_q || result.ready;

	always_comb begin
		pos_re    = 1'b0;
		pos_raddr = par_addr;
		case (state_q)
			S_RD_PAR: begin
				pos_re    = 1'b1;
				pos_raddr = par_addr;
			end
			S_RD_LEFT: begin
				pos_re    = 1'b1;
				pos_raddr = e_left[RANK_W-1:0];
			end
			S_RD_RIGHT: begin
				pos_re    = 1'b1;
				pos_raddr = e_right[RANK_W-1:0];
			end
			default: begin
				pos_re = 1'b0;
			end
		endcase
	end

	always_comb begin
		res_d              = '0;
		res_d.new_rank     = p_q;
		res_d.old_rank     = old_q;
		res_d.has_parent   = (old_q != '0);
		res_d.parent_rank  = (old_q != '0) ? par_q : '0;
		res_d.child_count  = {1'b0, e_has_l} + {1'b0, e_has_r};
		res_d.first_child  = e_has_l ? c1_q : '0;
		res_d.second_child = e_has_r ? pos_rd_q : '0;
		res_d.ring_prev    = (p_q == '0) ? RANK_W'(n_q - 1'b1) : p_q - 1'b1;
		res_d.ring_next    = e_last ? '0 : p_q + 1'b1;
		res_d.last_flag    = e_last;
	end

	// emit data registers
	always_ff @(posedge clk) begin
		if (state_q == S_RD_PAR) begin
			old_q <= ord_rd_q;
		end
		if (state_q == S_RD_LEFT) begin
			par_q <= pos_rd_q;
		end
		if (state_q == S_RD_RIGHT) begin
			c1_q <= pos_rd_q;
		end
		if (state_q == S_SEND && res_free) begin
			res_q <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			n_q         <= '0;
			cnt_q       <= '0;
			sp_q        <= '0;
			p_q         <= '0;
			res_valid_q <= 1'b0;
		end else begin
			res_valid_q <= (state_q == S_SEND && res_free) ||
			               (res_valid_q && !result.ready);
			case (state_q)
				S_IDLE: begin
					if (job.valid && job_ok) begin
						n_q     <= job.worker_count;
						cnt_q   <= '0;
						sp_q    <= SP_W'(1);
						p_q     <= '0;
						state_q <= S_WALK;
					end
				end
				S_WALK: begin
					if (w_pop) begin
						sp_q <= sp_q - 1'b1;
						if (sp_q == SP_W'(1)) begin
							state_q <= S_RD_ORD;
						end
					end else if (w_push) begin
						sp_q <= sp_q + 1'b1;
					end
					if (w_emit) begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_RD_ORD: begin
					state_q <= S_RD_PAR;
				end
				S_RD_PAR: begin
					state_q <= S_RD_LEFT;
				end
				S_RD_LEFT: begin
					state_q <= S_RD_RIGHT;
				end
				S_RD_RIGHT: begin
					state_q <= S_SEND;
				end
				S_SEND: begin
					if (res_free) begin
						p_q     <= p_q + 1'b1;
						state_q <= e_last ? S_IDLE : S_RD_ORD;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign result.valid        = res_valid_q;
	assign result.new_rank     = res_q.new_rank;
	assign result.old_rank     = res_q.old_rank;
	assign result.has_parent   = res_q.has_parent;
	assign result.parent_rank  = res_q.parent_rank;
	assign result.child_count  = res_q.child_count;
	assign result.first_child  = res_q.first_child;
	assign result.second_child = res_q.second_child;
	assign result.ring_prev    = res_q.ring_prev;
	assign result.ring_next    = res_q.ring_next;
	assign result.last_flag    = res_q.last_flag;

endmodule

`default_nettype wire

/* sv/trlm_checker.sv */
// port-level checks for the tree and ring link map, bound to the top level
// depends on trlm_pkg and tree_ring_link_map_top_defines.svh
`default_nettype none
`include "tree_ring_link_map_top_defines.svh"

module trlm_checker import trlm_pkg::*; (
	input wire        clk,
	input wire        arst_n,
	input wire        job_valid,
	input wire        job_ready,
	input wire [6:0]  worker_count,
	input wire        res_valid,
	input wire        res_ready,
	input wire [5:0]  new_rank,
	input wire        has_parent,
	input wire [5:0]  ring_next,
	input wire        last_flag
);

	logic job_good;
	assign job_good = job_valid && job_ready && (worker_count != 7'd0) &&
	                  ({1'b0, worker_count} <= 8'(MAX_WORKERS));

	`TRLM_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(new_rank), "result word changed while stalled")
	`TRLM_ASSERT_NEXT(a_busy_after_job, job_good, !job_ready, "job channel still ready after a valid job")
	`TRLM_ASSERT_SAME(a_root_only, res_valid, (new_rank == 6'd0) == !has_parent, "parent flag disagrees with rank zero")
	`TRLM_ASSERT_SAME(a_last_wraps, res_valid && last_flag, ring_next == 6'd0, "last word does not wrap the ring")

endmodule

bind tree_ring_link_map_top trlm_checker u_trlm_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.job_valid    (job.valid),
	.job_ready    (job.ready),
	.worker_count (job.worker_count),
	.res_valid    (result.valid),
	.res_ready    (result.ready),
	.new_rank     (result.new_rank),
	.has_parent   (result.has_parent),
	.ring_next    (result.ring_next),
	.last_flag    (result.last_flag)
);

`default_nettype wire

/* dv/tree_ring_link_map_top_test.sv */
// testbench for tree_ring_link_map_top: sends worker counts, predicts the relabelled
// heap tree and ring links for each word and checks every result word in order
// depends on trlm_pkg, trlm_job_if, trlm_res_if and tree_ring_link_map_top
`timescale 1ns / 100ps

module tree_ring_link_map_top_test;
	import trlm_pkg::*;

	localparam int unsigned RUN_LIMIT   = 1000000;
	localparam int unsigned DRAIN_WAIT  = 600;
	localparam int unsigned IDLE_PCT    = 17;
	localparam int unsigned REPORT_MAX  = 10;

	logic clk = 1'b0;
	logic arst_n;
	bit   steady;

	int unsigned cycle_count;
	int unsigned mismatch_count;
	int unsigned ring_seq[$];
	result_t     predicted_links[$];

	trlm_job_if job ();
	trlm_res_if result ();

	tree_ring_link_map_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.job    (job),
		.result (result)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= RUN_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// depth-first share ring: node first, first child as is, last child reversed; a reversed subtree runs backwards
	function automatic void walk_subtree(int unsigned node, bit rev, int unsigned n);
		int unsigned kids;
		int unsigned total;
		int unsigned j;
		kids = ((2 * node + 1 < n) ? 1 : 0) + ((2 * node + 2 < n) ? 1 : 0);
		total = 1 + kids;
		for (int unsigned s = 0; s < total; s++) begin
			j = rev ? (total - 1 - s) : s;
			if (j == 0) begin
				ring_seq.push_back(node);
			end else if (j == 1) begin
				walk_subtree(2 * node + 1, (kids == 1) ^ rev, n);
			end else begin
				walk_subtree(2 * node + 2, !rev, n);
			end
		end
	endfunction

	function automatic void predict_links(int unsigned n);
		int unsigned slot [MAX_WORKERS];
		int unsigned old;
		result_t     w;
		ring_seq.delete();
		walk_subtree(0, 1'b0, n);
		for (int unsigned p = 0; p < n; p++) slot[ring_seq[p]] = p;
		for (int unsigned p = 0; p < n; p++) begin
			old            = ring_seq[p];
			w              = '0;
			w.new_rank     = rank_t'(p);
			w.old_rank     = rank_t'(old);
			w.has_parent   = (old != 0);
			w.parent_rank  = (old != 0) ? rank_t'(slot[(old + 1) / 2 - 1]) : '0;
			w.child_count  = 2'((2 * old + 1 < n) ? 1 : 0) + 2'((2 * old + 2 < n) ? 1 : 0);
			w.first_child  = (2 * old + 1 < n) ? rank_t'(slot[2 * old + 1]) : '0;
			w.second_child = (2 * old + 2 < n) ? rank_t'(slot[2 * old + 2]) : '0;
			w.ring_prev    = rank_t'((p + n - 1) % n);
			w.ring_next    = rank_t'((p + 1) % n);
			w.last_flag    = (p == n - 1);
			predicted_links.push_back(w);
		end
	endfunction

	task automatic note_mismatch(string what, int unsigned want, int unsigned got);
		mismatch_count++;
		if (mismatch_count <= REPORT_MAX)
			$display("mismatch %s: expected %0d, got %0d", what, want, got);
	endtask

	always @(posedge clk) begin : link_check
		result_t want;
		if (arst_n && result.valid && result.ready) begin
			if (predicted_links.size() == 0) begin
				note_mismatch("unexpected word, new_rank", 0, result.new_rank);
			end else begin
				want = predicted_links.pop_front();
				if (result.new_rank !== want.new_rank)
					note_mismatch("new_rank", want.new_rank, result.new_rank);
				if (result.old_rank !== want.old_rank)
					note_mismatch("old_rank", want.old_rank, result.old_rank);
				if (result.has_parent !== want.has_parent)
					note_mismatch("has_parent", want.has_parent, result.has_parent);
				if (result.parent_rank !== want.parent_rank)
					note_mismatch("parent_rank", want.parent_rank, result.parent_rank);
				if (result.child_count !== want.child_count)
					note_mismatch("child_count", want.child_count, result.child_count);
				if (result.first_child !== want.first_child)
					note_mismatch("first_child", want.first_child, result.first_child);
				if (result.second_child !== want.second_child)
					note_mismatch("second_child", want.second_child, result.second_child);
				if (result.ring_prev !== want.ring_prev)
					note_mismatch("ring_prev", want.ring_prev, result.ring_prev);
				if (result.ring_next !== want.ring_next)
					note_mismatch("ring_next", want.ring_next, result.ring_next);
				if (result.last_flag !== want.last_flag)
					note_mismatch("last_flag", want.last_flag, result.last_flag);
			end
		end
		result.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
	end

	task automatic send_count(logic [6:0] n);
		if (!steady && $urandom_range(99) < IDLE_PCT) begin
			job.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < IDLE_PCT);
		end
		job.valid        <= 1'b1;
		job.worker_count <= n;
		do @(posedge clk); while (!job.ready);
		if (n >= 1 && n <= MAX_WORKERS)
			predict_links(n);
	endtask

	function automatic logic [6:0] pick_count();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 10)
			return ($urandom_range(1) == 0) ? 7'd0 : 7'($urandom_range(127, MAX_WORKERS + 1));
		else if (r < 65)
			return 7'($urandom_range(16, 1));
		else
			return 7'($urandom_range(MAX_WORKERS, 17));
	endfunction

	task automatic apply_reset();
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
	endtask

	task automatic test_small_trees();
		for (int unsigned n = 1; n <= 8; n++) send_count(7'(n));
	endtask

	task automatic test_extreme_counts();
		send_count(7'd64);
		send_count(7'd63);
		send_count(7'd32);
		send_count(7'd33);
		send_count(7'd15);
		send_count(7'd16);
		send_count(7'd64);
	endtask

	task automatic test_rejected_counts();
		send_count(7'd0);
		send_count(7'd1);
		send_count(7'd65);
		send_count(7'd127);
		send_count(7'd96);
		send_count(7'd2);
	endtask

	task automatic test_random_counts();
		logic [6:0]  n;
		int unsigned sent;
		sent = 0;
		while (sent < 80) begin
			n = pick_count();
			send_count(n);
			if (n >= 1 && n <= MAX_WORKERS) sent++;
		end
	endtask

	task automatic test_back_to_back();
		logic [6:0]  n;
		int unsigned sent;
		steady = 1'b1;
		sent = 0;
		while (sent < 60) begin
			n = pick_count();
			send_count(n);
			if (n >= 1 && n <= MAX_WORKERS) sent++;
		end
		steady = 1'b0;
	endtask

	initial begin
		steady           = 1'b0;
		job.valid        = 1'b0;
		job.worker_count = '0;
		apply_reset();
		test_small_trees();
		test_extreme_counts();
		test_rejected_counts();
		test_random_counts();
		test_back_to_back();
		test_random_counts();
		job.valid <= 1'b0;
		while (predicted_links.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

/* tree_ring_link_map_top.f */
+incdir+sv
sv/trlm_pkg.sv
sv/trlm_job_if.sv
sv/trlm_res_if.sv
sv/tree_ring_link_map_top.sv
sv/trlm_checker.sv
dv/tree_ring_link_map_top_test.sv
